// ----- design/sqms_pkg.sv -----
// shared types and constants for the shift queue with max search
`timescale 1ns / 1ps
`default_nettype none

package sqms_pkg;

  localparam int PAYLOAD_W = 32;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2,
    CMD_MAX  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

endpackage

`default_nettype wire

// ----- design/sqms_if.sv -----
// request and result channel interfaces of the shift queue
`timescale 1ns / 1ps
`default_nettype none

interface sqms_in_if #(
  parameter int KEY_BITS = 8,
  parameter int POS_W    = 4
) ();
  logic                           valid;
  logic                           ready;
  logic [sqms_pkg::CMD_W-1:0]     command;
  logic [sqms_pkg::PAYLOAD_W-1:0] entry_payload;
  logic [KEY_BITS-1:0]            entry_key;
  logic [POS_W-1:0]               position;

  modport source (output valid, command, entry_payload, entry_key, position, input ready);
  modport sink   (input valid, command, entry_payload, entry_key, position, output ready);
endinterface

interface sqms_out_if #(
  parameter int KEY_BITS = 8,
  parameter int POS_W    = 4,
  parameter int CNT_W    = 5
) ();
  logic                           valid;
  logic                           ready;
  logic [sqms_pkg::STATUS_W-1:0]  status;
  logic [sqms_pkg::PAYLOAD_W-1:0] out_payload;
  logic [KEY_BITS-1:0]            out_key;
  logic [POS_W-1:0]               out_position;
  logic [CNT_W-1:0]               occupancy;

  modport source (output valid, status, out_payload, out_key, out_position, occupancy,
                  input ready);
  modport sink   (input valid, status, out_payload, out_key, out_position, occupancy,
                  output ready);
endinterface

`default_nettype wire

// ----- design/shift_queue_with_max_search.sv -----
// top level: bounded queue with pop, peek and largest-key search
//
//   channel   dir   handshake          carries
//   in_req    in    valid/ready        command, entry_payload, entry_key, position
//   out_rsp   out   valid/ready        status, out_payload, out_key, out_position, occupancy
//   cfg       in    cfg_we             capacity (cfg_wdata)
//
// push and every rejected request give a registered result in the cycle after acceptance.
// pop and peek read a single entry and find max reads every entry: one
// storage read port and one key comparator walk the entries one per cycle.
// the queue is a circular buffer, so pop moves the head instead of the data.
// rst_n is synchronous; it empties the queue and sets capacity to DEPTH.
// a stalled result holds off new requests, and a finished scan waits for it.
`timescale 1ns / 1ps
`default_nettype none

module shift_queue_with_max_search #(
  parameter int DEPTH    = 16,
  parameter int KEY_BITS = 8,
  localparam int POS_W   = $clog2(DEPTH),
  localparam int CNT_W   = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  sqms_in_if.sink          in_req,
  sqms_out_if.source       out_rsp
);

  localparam int ENT_W = sqms_pkg::PAYLOAD_W + KEY_BITS;

  function automatic logic [POS_W-1:0] wrap_add(input logic [POS_W-1:0] a,
                                                input logic [POS_W-1:0] b);
    logic [POS_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (POS_W + 1)'(DEPTH)) begin
      s = s - (POS_W + 1)'(DEPTH);
    end
    return s[POS_W-1:0];
  endfunction

  sqms_pkg::state_t  state_r, state_nxt;
  sqms_pkg::cmd_t    op_r, op_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  cap_r;
  logic [POS_W-1:0]  head_r, head_nxt;
  logic [POS_W-1:0]  idx_r, idx_nxt;
  logic [POS_W-1:0]  last_r, last_nxt;
  logic [POS_W-1:0]  pidx_r, pidx_nxt;
  logic              pend_r, pend_nxt;
  logic              first_r, first_nxt;

  logic [sqms_pkg::PAYLOAD_W-1:0] best_pay_r, best_pay_nxt;
  logic [KEY_BITS-1:0]            best_key_r, best_key_nxt;
  logic [POS_W-1:0]               best_pos_r, best_pos_nxt;

  logic                           out_vld_r, out_vld_nxt;
  sqms_pkg::status_t              ostat_r, ostat_nxt;
  logic [sqms_pkg::PAYLOAD_W-1:0] opay_r, opay_nxt;
  logic [KEY_BITS-1:0]            okey_r, okey_nxt;
  logic [POS_W-1:0]               opos_r, opos_nxt;
  logic [CNT_W-1:0]               ocnt_r, ocnt_nxt;

  logic [CNT_W-1:0]               eff_cap;
  logic                           q_full;
  logic                           q_empty;
  logic                           out_free;
  sqms_pkg::cmd_t                 in_cmd;
  logic                           wr_en;
  logic [POS_W-1:0]               wr_addr;
  logic [POS_W-1:0]               rd_addr;
  logic [ENT_W-1:0]               rd_data;
  logic [sqms_pkg::PAYLOAD_W-1:0] rd_pay;
  logic [KEY_BITS-1:0]            rd_key;

  sqms_store #(
    .DEPTH (DEPTH),
    .WIDTH (ENT_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({in_req.entry_payload, in_req.entry_key}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_pay  = rd_data[ENT_W-1:KEY_BITS];
  assign rd_key  = rd_data[KEY_BITS-1:0];
  assign rd_addr = wrap_add(head_r, idx_r);
  assign wr_addr = wrap_add(head_r, cnt_r[POS_W-1:0]);
  assign in_cmd  = sqms_pkg::cmd_t'(in_req.command);

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CNT_W'(1);
    end else if (cap_r > CNT_W'(DEPTH)) begin
      eff_cap = CNT_W'(DEPTH);
    end else begin
      eff_cap = cap_r;
    end
  end

  assign q_full   = (cnt_r >= eff_cap);
  assign q_empty  = (cnt_r == '0);
  assign out_free = !out_vld_r || out_rsp.ready;

  assign in_req.ready = (state_r == sqms_pkg::S_IDLE) && out_free;

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    cnt_nxt      = cnt_r;
    head_nxt     = head_r;
    idx_nxt      = idx_r;
    last_nxt     = last_r;
    pidx_nxt     = pidx_r;
    pend_nxt     = 1'b0;
    first_nxt    = first_r;
    best_pay_nxt = best_pay_r;
    best_key_nxt = best_key_r;
    best_pos_nxt = best_pos_r;
    out_vld_nxt  = out_vld_r && !out_rsp.ready;
    ostat_nxt    = ostat_r;
    opay_nxt     = opay_r;
    okey_nxt     = okey_r;
    opos_nxt     = opos_r;
    ocnt_nxt     = ocnt_r;
    wr_en        = 1'b0;

    // shared comparator: first entry seeds, later ones win only when strictly larger
    if (pend_r) begin
      if (first_r || (rd_key > best_key_r)) begin
        best_pay_nxt = rd_pay;
        best_key_nxt = rd_key;
        best_pos_nxt = pidx_r;
      end
      first_nxt = 1'b0;
    end

    case (state_r)
      sqms_pkg::S_IDLE: begin
        if (in_req.valid && out_free) begin
          op_nxt    = in_cmd;
          first_nxt = 1'b1;
          opay_nxt  = '0;
          okey_nxt  = '0;
          opos_nxt  = '0;
          ocnt_nxt  = cnt_r;
          case (in_cmd)
            sqms_pkg::CMD_PUSH: begin
              out_vld_nxt = 1'b1;
              if (q_full) begin
                ostat_nxt = sqms_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                cnt_nxt   = cnt_r + CNT_W'(1);
                ocnt_nxt  = cnt_r + CNT_W'(1);
                ostat_nxt = sqms_pkg::ST_OK;
              end
            end
            sqms_pkg::CMD_POP: begin
              if (q_empty) begin
                out_vld_nxt = 1'b1;
                ostat_nxt   = sqms_pkg::ST_EMPTY;
              end else begin
                idx_nxt   = '0;
                last_nxt  = '0;
                state_nxt = sqms_pkg::S_SCAN;
              end
            end
            sqms_pkg::CMD_PEEK: begin
              if (CNT_W'(in_req.position) >= cnt_r) begin
                out_vld_nxt = 1'b1;
                ostat_nxt   = sqms_pkg::ST_RANGE;
              end else begin
                idx_nxt   = in_req.position;
                last_nxt  = in_req.position;
                state_nxt = sqms_pkg::S_SCAN;
              end
            end
            sqms_pkg::CMD_MAX: begin
              if (q_empty) begin
                out_vld_nxt = 1'b1;
                ostat_nxt   = sqms_pkg::ST_EMPTY;
              end else begin
                idx_nxt   = '0;
                last_nxt  = POS_W'(cnt_r - CNT_W'(1));
                state_nxt = sqms_pkg::S_SCAN;
              end
            end
            default: begin
              out_vld_nxt = out_vld_r && !out_rsp.ready;
            end
          endcase
        end
      end
      sqms_pkg::S_SCAN: begin
        pend_nxt = 1'b1;
        pidx_nxt = idx_r;
        if (idx_r == last_r) begin
          state_nxt = sqms_pkg::S_DONE;
        end else begin
          idx_nxt = idx_r + POS_W'(1);
        end
      end
      sqms_pkg::S_DONE: begin
        if (!pend_r && out_free) begin
          out_vld_nxt = 1'b1;
          ostat_nxt   = sqms_pkg::ST_OK;
          opay_nxt    = best_pay_r;
          okey_nxt    = best_key_r;
          opos_nxt    = (op_r == sqms_pkg::CMD_MAX) ? best_pos_r : '0;
          ocnt_nxt    = cnt_r;
          if (op_r == sqms_pkg::CMD_POP) begin
            head_nxt = wrap_add(head_r, POS_W'(1));
            cnt_nxt  = cnt_r - CNT_W'(1);
            ocnt_nxt = cnt_r - CNT_W'(1);
          end
          state_nxt = sqms_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sqms_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sqms_pkg::S_IDLE;
      cnt_r     <= '0;
      head_r    <= '0;
      pend_r    <= 1'b0;
      first_r   <= 1'b0;
      out_vld_r <= 1'b0;
      cap_r     <= CNT_W'(DEPTH);
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      head_r    <= head_nxt;
      pend_r    <= pend_nxt;
      first_r   <= first_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    idx_r      <= idx_nxt;
    last_r     <= last_nxt;
    pidx_r     <= pidx_nxt;
    best_pay_r <= best_pay_nxt;
    best_key_r <= best_key_nxt;
    best_pos_r <= best_pos_nxt;
    ostat_r    <= ostat_nxt;
    opay_r     <= opay_nxt;
    okey_r     <= okey_nxt;
    opos_r     <= opos_nxt;
    ocnt_r     <= ocnt_nxt;
  end

  assign out_rsp.valid        = out_vld_r;
  assign out_rsp.status       = ostat_r;
  assign out_rsp.out_payload  = opay_r;
  assign out_rsp.out_key      = okey_r;
  assign out_rsp.out_position = opos_r;
  assign out_rsp.occupancy    = ocnt_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_full_real: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && ostat_r == sqms_pkg::ST_FULL) |-> (ocnt_r >= eff_cap))
    else $error("full reported below capacity");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && opos_r != '0) |-> (ostat_r == sqms_pkg::ST_OK && CNT_W'(opos_r) < ocnt_r))
    else $error("reported position outside queue");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sqms_pkg::S_SCAN) |-> (idx_r <= last_r))
    else $error("scan index ran past last entry");

endmodule

`default_nettype wire

// ----- design/sqms_store.sv -----
// entry storage: one write port, one read port with registered read data
`timescale 1ns / 1ps
`default_nettype none

module sqms_store #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 40,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire
